// File: rtl/hdlc_pkg.sv
package hdlc_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

  localparam int ONES_FLAG = 5;
  localparam int ONES_SAT  = 6;
  localparam int LEN_W     = 12;

  // register indexes on the configuration port
  localparam logic CFG_MIN_LENGTH = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_OVERLONG = 2'd3
  } status_t;

  typedef struct packed {
    logic             valid;
    logic [7:0]       data_byte;
    logic             last;
    status_t          status;
    logic [LEN_W-1:0] frame_length;
  } hdlc_result_t;

  // reflected crc-16 ccitt over one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/hdlc_core.sv
module hdlc_core import hdlc_pkg::*; #(
  parameter int MAX_LIMIT = 4095
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             line_bit,
  input  logic [LEN_W-1:0] min_length,
  input  logic [LEN_W-1:0] max_length,
  output hdlc_result_t     result
);

  // byte count reaches at most the limit plus one
  localparam int CW = $clog2(MAX_LIMIT + 2);
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;

  logic [2:0]    ones_run, ones_run_next;
  logic [2:0]    bit_count, bit_count_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic [7:0]    held_old, held_old_next;
  logic [7:0]    held_new, held_new_next;
  logic [15:0]   crc_reg, crc_reg_next;

  logic [LW-1:0] bc_ext;
  logic [LW-1:0] limit;
  logic [LW-1:0] max_ext;
  logic [LW-1:0] payload_full;
  logic [LEN_W-1:0] payload;
  logic [7:0]    shifted;

  always_comb begin
    bc_ext  = LW'(byte_count);
    max_ext = LW'(max_length);
    limit   = (max_ext < LW'(MAX_LIMIT)) ? max_ext : LW'(MAX_LIMIT);
    payload_full = bc_ext - LW'(2);
    payload = (bc_ext >= LW'(2)) ? payload_full[LEN_W-1:0] : '0;
    shifted = {line_bit, shift_byte[7:1]};
  end

  always_comb begin
    ones_run_next   = ones_run;
    bit_count_next  = bit_count;
    byte_count_next = byte_count;
    shift_byte_next = shift_byte;
    held_old_next   = held_old;
    held_new_next   = held_new;
    crc_reg_next    = crc_reg;
    result          = '0;
    result.status   = ST_GOOD;

    if (ones_run >= 3'(ONES_FLAG)) begin
      // after five ones: zero is a stuffed bit, one is a flag
      if (line_bit) begin
        if (bc_ext >= LW'(3)) begin
          result.valid        = 1'b1;
          result.last         = 1'b1;
          result.frame_length = payload;
          if (bc_ext >= LW'(min_length)) begin
            result.status = ({held_new, held_old} == (crc_reg ^ CRC_XOROUT)) ?
                            ST_GOOD : ST_CRC_ERR;
          end else begin
            result.status = ST_SHORT;
          end
        end
        bit_count_next  = '0;
        byte_count_next = '0;
        crc_reg_next    = CRC_INIT;
      end
    end else if (bc_ext > limit) begin
      result.valid        = 1'b1;
      result.last         = 1'b1;
      result.status       = ST_OVERLONG;
      result.frame_length = payload;
      bit_count_next  = '0;
      byte_count_next = '0;
      crc_reg_next    = CRC_INIT;
    end else begin
      shift_byte_next = shifted;
      bit_count_next  = bit_count + 3'd1;
      if (bit_count == 3'd7) begin
        // byte leaves the two-byte fcs delay line
        if (bc_ext >= LW'(2)) begin
          result.valid     = 1'b1;
          result.data_byte = held_old;
          crc_reg_next     = crc_byte(crc_reg, held_old);
        end
        held_old_next   = held_new;
        held_new_next   = shifted;
        byte_count_next = byte_count + CW'(1);
      end
    end

    if (line_bit) begin
      ones_run_next = (ones_run >= 3'(ONES_SAT)) ? 3'(ONES_SAT) : ones_run + 3'd1;
    end else begin
      ones_run_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_run   <= '0;
      bit_count  <= '0;
      byte_count <= '0;
      shift_byte <= '0;
      held_old   <= '0;
      held_new   <= '0;
      crc_reg    <= CRC_INIT;
    end else if (step) begin
      ones_run   <= ones_run_next;
      bit_count  <= bit_count_next;
      byte_count <= byte_count_next;
      shift_byte <= shift_byte_next;
      held_old   <= held_old_next;
      held_new   <= held_new_next;
      crc_reg    <= crc_reg_next;
    end
  end

endmodule

// File: rtl/hdlc_bit_deframer_crc.sv
// hdlc bit deframer with crc-16 ccitt check, one line bit per item
// an accepted bit is held in the input register, then hdlc_core writes its result into the output register
// throughput: one item per cycle unless a result waits on m_tready; the single-pass bit logic in hdlc_core sets it
// an item that ends no byte and no frame gives no result
// reset (rst, synchronous): pipeline empty, frame state cleared, crc at ffff,
// min_length 32 and max_length 500
module hdlc_bit_deframer_crc import hdlc_pkg::*; #(
  parameter int MAX_LIMIT = 4095
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [0] line_bit, rest zero
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // [7:0] data_byte, [19:8] frame_length, rest zero
  output logic             m_tlast,
  output logic [1:0]       m_tuser,   // [1:0] status
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data
);

  logic [LEN_W-1:0] min_length;
  logic [LEN_W-1:0] max_length;
  logic             in_full;
  logic             in_bit;
  logic             step;
  hdlc_result_t     result;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;
  status_t          out_status;
  logic [LEN_W-1:0] out_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= LEN_W'(32);
      max_length <= LEN_W'(500);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LENGTH: min_length <= cfg_data;
        CFG_MAX_LENGTH: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // process the held item when the result register is free or draining
  assign step     = in_full && (!out_valid || m_tready);
  assign s_tready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_bit <= s_tdata[0];
    end
  end

  hdlc_core #(
    .MAX_LIMIT(MAX_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .line_bit  (in_bit),
    .min_length(min_length),
    .max_length(max_length),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      out_byte   <= result.data_byte;
      out_last   <= result.last;
      out_status <= result.status;
      out_len    <= result.frame_length;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'h0, out_len, out_byte};
  assign m_tlast  = out_last;
  assign m_tuser  = out_status;

`ifndef NO_ASSERTIONS
  a_step_needs_item: assert property (@(posedge clk) disable iff (rst)
    step |-> in_full)
    else $error("core stepped without a held item");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_full && out_valid && !m_tready))
    else $error("input stalled without a blocked result");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == 2'd0 && m_tdata[19:8] == '0))
    else $error("payload item carries end fields");

  a_end_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[7:0] == 8'h00))
    else $error("end item carries a data byte");
`endif

endmodule

// File: sim/hdlc_frame_checker.sv
`timescale 1ns / 1ps
module hdlc_frame_checker import hdlc_pkg::*; #(
  parameter int MAX_LIMIT = 4095
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,   // [0] line_bit, rest zero
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [23:0]      m_tdata,   // [7:0] data_byte, [19:8] frame_length, rest zero
  input  logic             m_tlast,
  input  logic [1:0]       m_tuser,   // [1:0] status
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data,
  output int               mismatches,
  output int               pending,
  output int               bytes_checked,
  output int               ends_checked,
  output int               n_good,
  output int               n_crc_err,
  output int               n_short,
  output int               n_overlong
);

  typedef struct {
    logic [7:0]       data_byte;
    logic             last;
    status_t          status;
    logic [LEN_W-1:0] frame_length;
  } rx_item_t;

  rx_item_t rx_expect_q[$];

  // deframer state as the block should hold it
  logic [LEN_W-1:0] min_len;
  logic [LEN_W-1:0] max_len;
  logic [2:0]       run_ones;
  logic [2:0]       nbits;
  logic [12:0]      nbytes;
  logic [7:0]       shreg;
  logic [7:0]       held_old;
  logic [7:0]       held_new;
  logic [15:0]      fcs_acc;

  rx_item_t         want;
  logic [7:0]       got_byte;
  logic [LEN_W-1:0] got_len;

  function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] d);
    for (int i = 0; i < 8; i++) begin
      if (acc[0] ^ d[i]) begin
        acc = (acc >> 1) ^ 16'h8408;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  task automatic frame_end(input status_t st);
    rx_item_t e;
    e.data_byte    = 8'h00;
    e.last         = 1'b1;
    e.status       = st;
    e.frame_length = (nbytes >= 13'd2) ? LEN_W'(nbytes - 13'd2) : '0;
    rx_expect_q.push_back(e);
  endtask

  task automatic deframe_bit(input logic lb);
    rx_item_t   e;
    logic [12:0] limit;
    limit = (max_len < MAX_LIMIT) ? 13'(max_len) : 13'(MAX_LIMIT);
    if (run_ones >= ONES_FLAG) begin
      // sixth one is a flag, a zero after five ones is stuffing
      if (lb) begin
        if (nbytes >= 13'd3) begin
          if (nbytes >= 13'(min_len)) begin
            frame_end(({held_new, held_old} == ~fcs_acc) ? ST_GOOD : ST_CRC_ERR);
          end else begin
            frame_end(ST_SHORT);
          end
        end
        nbits   = '0;
        nbytes  = '0;
        fcs_acc = CRC_INIT;
      end
    end else if (nbytes > limit) begin
      frame_end(ST_OVERLONG);
      nbits   = '0;
      nbytes  = '0;
      fcs_acc = CRC_INIT;
    end else begin
      shreg = {lb, shreg[7:1]};
      if (nbits == 3'd7) begin
        nbits = '0;
        // bytes leave two behind so the fcs never shows up as payload
        if (nbytes >= 13'd2) begin
          e.data_byte    = held_old;
          e.last         = 1'b0;
          e.status       = ST_GOOD;
          e.frame_length = '0;
          rx_expect_q.push_back(e);
          fcs_acc = fcs_update(fcs_acc, held_old);
        end
        held_old = held_new;
        held_new = shreg;
        nbytes   = nbytes + 13'd1;
      end else begin
        nbits = nbits + 3'd1;
      end
    end
    if (lb) begin
      run_ones = (run_ones >= ONES_SAT) ? 3'(ONES_SAT) : run_ones + 3'd1;
    end else begin
      run_ones = '0;
    end
  endtask

  task automatic report_bad(input string what, input rx_item_t e);
    if (mismatches < 10) begin
      $display("%0t: %s: expected byte %02h last %0d status %0d length %0d, got byte %02h last %0d status %0d length %0d",
               $time, what, e.data_byte, e.last, e.status, e.frame_length,
               got_byte, m_tlast, m_tuser, got_len);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_expect_q.delete();
      min_len  = 12'd32;
      max_len  = 12'd500;
      run_ones = '0;
      nbits    = '0;
      nbytes   = '0;
      shreg    = '0;
      held_old = '0;
      held_new = '0;
      fcs_acc  = CRC_INIT;
    end else begin
      if (s_tvalid && s_tready) begin
        deframe_bit(s_tdata[0]);
      end
      if (m_tvalid && m_tready) begin
        got_byte = m_tdata[7:0];
        got_len  = m_tdata[19:8];
        if (rx_expect_q.size() == 0) begin
          want.data_byte    = 'x;
          want.last         = 'x;
          want.status       = ST_GOOD;
          want.frame_length = 'x;
          report_bad("item with nothing expected", want);
        end else begin
          want = rx_expect_q.pop_front();
          if (want.data_byte !== got_byte || want.last !== m_tlast ||
              want.status !== m_tuser || want.frame_length !== got_len) begin
            report_bad("result mismatch", want);
          end
          if (!want.last) begin
            bytes_checked++;
          end else begin
            ends_checked++;
            case (want.status)
              ST_GOOD:     n_good++;
              ST_CRC_ERR:  n_crc_err++;
              ST_SHORT:    n_short++;
              ST_OVERLONG: n_overlong++;
              default:     ;
            endcase
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_LENGTH) begin
          min_len = cfg_data;
        end else begin
          max_len = cfg_data;
        end
      end
    end
    pending = rx_expect_q.size();
  end

endmodule

// File: sim/hdlc_bit_deframer_crc_tb.sv
`timescale 1ns / 1ps
module hdlc_bit_deframer_crc_tb import hdlc_pkg::*;;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_BITS      = 200;
  localparam int NUM_KINDS       = 7;

  typedef enum int {
    FR_GOOD,
    FR_BAD_FCS,
    FR_PARTIAL,
    FR_TWO_BYTE,
    FR_EMPTY,
    FR_ABORT,
    FR_NOISE
  } frame_kind_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;   // [0] line_bit, rest zero
  logic             m_tvalid;
  logic             m_tready;
  logic [23:0]      m_tdata;   // [7:0] data_byte, [19:8] frame_length, rest zero
  logic             m_tlast;
  logic [1:0]       m_tuser;   // [1:0] status
  logic             cfg_we;
  logic             cfg_index;
  logic [LEN_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int bytes_checked;
  int ends_checked;
  int n_good;
  int n_crc_err;
  int n_short;
  int n_overlong;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_reqs;
  int bits_sent;
  int tx_ones;
  int cycle_count;

  hdlc_bit_deframer_crc u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hdlc_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .bytes_checked (bytes_checked),
    .ends_checked  (ends_checked),
    .n_good        (n_good),
    .n_crc_err     (n_crc_err),
    .n_short       (n_short),
    .n_overlong    (n_overlong)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("hdlc_bit_deframer_crc_tb: FAIL");
      $finish;
    end
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int held;
    int served;
    m_tready = 1'b0;
    served   = 0;
    forever begin
      @(negedge clk);
      if (hold_off_reqs != served) begin
        served++;
        m_tready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
          @(negedge clk);
        end
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_bit(input logic lb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lb};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bits_sent++;
  endtask

  task automatic send_stuffed(input logic lb);
    send_bit(lb);
    if (lb) begin
      tx_ones++;
      if (tx_ones == 5) begin
        send_bit(1'b0);
        tx_ones = 0;
      end
    end else begin
      tx_ones = 0;
    end
  endtask

  task automatic send_flag();
    logic [7:0] flag;
    flag = 8'h7E;
    for (int i = 0; i < 8; i++) begin
      send_bit(flag[i]);
    end
    tx_ones = 0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return FR_GOOD;
    if (r < 65) return FR_BAD_FCS;
    if (r < 75) return FR_PARTIAL;
    if (r < 82) return FR_TWO_BYTE;
    if (r < 87) return FR_EMPTY;
    if (r < 93) return FR_ABORT;
    return FR_NOISE;
  endfunction

  // payload plus fcs (low byte first), stuffed, then a closing flag; empty, abort and noise frames send no fcs
  task automatic send_frame(input frame_kind_t kind, input int npay);
    logic [7:0]  body[$];
    logic [7:0]  v;
    logic [15:0] acc;
    int          pos;
    acc = 16'hFFFF;
    case (kind)
      FR_EMPTY: ;
      FR_NOISE: begin
        // ones-heavy noise runs into stray flags and aborts
        repeat ($urandom_range(4, 30)) send_bit($urandom_range(0, 99) < 70);
      end
      FR_ABORT: begin
        repeat (npay) begin
          v = pick_byte();
          for (int i = 0; i < 8; i++) send_stuffed(v[i]);
        end
        send_bit(1'b0);
        repeat ($urandom_range(7, 12)) send_bit(1'b1);
      end
      default: begin
        if (kind == FR_TWO_BYTE) begin
          npay = 0;
        end
        repeat (npay) begin
          v = pick_byte();
          body.push_back(v);
          for (int i = 0; i < 8; i++) begin
            acc = (acc[0] ^ v[i]) ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
          end
        end
        acc = ~acc;
        body.push_back(acc[7:0]);
        body.push_back(acc[15:8]);
        if (kind == FR_BAD_FCS) begin
          pos = $urandom_range(0, body.size() - 1);
          body[pos][$urandom_range(0, 7)] ^= 1'b1;
        end
        foreach (body[j]) begin
          v = body[j];
          for (int i = 0; i < 8; i++) send_stuffed(v[i]);
        end
        if (kind == FR_PARTIAL) begin
          repeat ($urandom_range(1, 7)) send_stuffed($urandom_range(0, 1));
        end
      end
    endcase
    send_flag();
  endtask

  // sender stops until every expected result is out, then lets the pipe empty
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int          start;
    int          k;
    frame_kind_t kind;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_MIN_LENGTH;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_reqs  = 0;
    bits_sent      = 0;
    tx_ones        = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: empty frame, then the shortest frame that gives an end
    send_flag();
    send_frame(FR_EMPTY, 0);
    send_frame(FR_GOOD, 1);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(CFG_MIN_LENGTH, 12'd3);
          write_reg(CFG_MAX_LENGTH, 12'd4095);
          send_idle_pct  = 48;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(CFG_MIN_LENGTH, 12'd4095);
          write_reg(CFG_MAX_LENGTH, 12'd3);
          send_idle_pct  = 0;
          recv_stall_pct = 48;
        end
        default: begin
          write_reg(CFG_MIN_LENGTH, 12'($urandom_range(0, 8)));
          write_reg(CFG_MAX_LENGTH, 12'($urandom_range(0, 24)));
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      if (phase == 0) begin
        // frame against a long receiver stall backs up into the input
        hold_off_reqs++;
        send_frame(FR_GOOD, 6);
      end
      start = bits_sent;
      k = 0;
      while (bits_sent - start < PHASE_BITS || k < NUM_KINDS) begin
        kind = (k < NUM_KINDS) ? frame_kind_t'(k) : pick_kind();
        send_frame(kind, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                     : $urandom_range(1, 4));
        k++;
      end
    end
    drain();

    $display("%0d line bits sent over four settings and idle patterns", bits_sent);
    $display("%0d payload bytes, %0d frame ends", bytes_checked, ends_checked);
    $display("(good %0d, crc error %0d, short %0d, overlong %0d)",
             n_good, n_crc_err, n_short, n_overlong);
    if (mismatches == 0 && pending == 0) begin
      $display("hdlc_bit_deframer_crc_tb: PASS");
    end else begin
      $display("hdlc_bit_deframer_crc_tb: FAIL");
    end
    $finish;
  end

endmodule
